>>> rtl/izhikevich_neuron_step_core_macros.svh
// Assertion macros for the Izhikevich neuron step core checker.
// Used by izn_checker.sv; no other dependencies.
`ifndef IZHIKEVICH_NEURON_STEP_CORE_MACROS_SVH
`define IZHIKEVICH_NEURON_STEP_CORE_MACROS_SVH

// same-cycle implication
`define IZN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IZN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/izn_pkg.sv
// Shared constants and saturation helper for the Izhikevich neuron step core.
// No dependencies; imported by every RTL module of the block.
package izn_pkg;

   localparam int DATA_W       = 32;
   localparam int DT_W         = 21;
   localparam int IDX_W        = 3;
   localparam int PART_W       = 36;
   localparam int DIV_W        = 40;
   localparam int DIV_HALF_W   = 20;
   localparam int DIV_LO_W     = 17;
   localparam int DIV_RECIP_SH = 26;
   localparam int QUOT_W       = 36;

   localparam logic [IDX_W-1:0] REG_A    = 3'd0;
   localparam logic [IDX_W-1:0] REG_B    = 3'd1;
   localparam logic [IDX_W-1:0] REG_C    = 3'd2;
   localparam logic [IDX_W-1:0] REG_D    = 3'd3;
   localparam logic [IDX_W-1:0] REG_PEAK = 3'd4;
   localparam logic [IDX_W-1:0] REG_DT   = 3'd5;

   localparam logic signed [DATA_W-1:0] RST_A    = 32'sd1311;
   localparam logic signed [DATA_W-1:0] RST_B    = 32'sd13107;
   localparam logic signed [DATA_W-1:0] RST_C    = -32'sd4259840;
   localparam logic signed [DATA_W-1:0] RST_D    = 32'sd524288;
   localparam logic signed [DATA_W-1:0] RST_PEAK = 32'sd1966080;
   localparam logic [DT_W-1:0]          RST_DT   = 21'd65536;
   localparam logic signed [DATA_W-1:0] RST_U    = -32'sd851968;

   localparam logic signed [PART_W-1:0] K140     = 36'sd9175040;

   // 2^20 = 25 * 41943 + 1; 2684355 = ceil(2^26 / 25)
   localparam logic signed [DATA_W-1:0] DIV_SPLIT_K = 32'sd41943;
   localparam logic signed [DATA_W-1:0] DIV_RECIP   = 32'sd2684355;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
      logic signed [DATA_W-1:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < 64'shFFFF_FFFF_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/izn_mult.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on izn_pkg.
module izn_mult (
   input  logic                              clock,
   input  logic signed [izn_pkg::DATA_W-1:0] op_a,
   input  logic signed [izn_pkg::DATA_W-1:0] op_b,
   output logic signed [63:0]                prod_ff
);
   import izn_pkg::*;

   logic signed [63:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> rtl/izn_div25.sv
// Divide by 25 for the 0.04*v*v term: split of the scaled square plus a reciprocal product,
// both products taken from the shared multiplier. Depends on izn_pkg.
module izn_div25 (
   input  logic                              clock,
   input  logic                              split,
   input  logic                              hold_hi,
   input  logic signed [63:0]                prod,
   output logic signed [izn_pkg::DATA_W-1:0] hi_factor,
   output logic signed [izn_pkg::DATA_W-1:0] lo_factor,
   output logic [izn_pkg::QUOT_W-1:0]        quot
);
   import izn_pkg::*;

   logic [DIV_W-1:0]      scaled;
   logic [DIV_HALF_W-1:0] hi_ff, hi_in;
   logic [DIV_HALF_W:0]   lo_ff, lo_in;
   logic [QUOT_W-1:0]     qhi_ff, qhi_in;

   assign scaled = (|prod[63:56]) ? {DIV_W{1'b1}} : prod[55:16];

   assign hi_in  = split ? scaled[DIV_W-1:DIV_HALF_W] : hi_ff;
   assign lo_in  = split ? ({1'b0, scaled[DIV_W-1:DIV_HALF_W]} +
                            {1'b0, scaled[DIV_HALF_W-1:0]}) : lo_ff;
   assign qhi_in = hold_hi ? prod[QUOT_W-1:0] : qhi_ff;

   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      qhi_ff <= qhi_in;
   end

   assign hi_factor = {{(DATA_W-DIV_HALF_W){1'b0}}, hi_ff};
   assign lo_factor = {{(DATA_W-DIV_HALF_W-1){1'b0}}, lo_ff};
   assign quot      = qhi_ff + {{(QUOT_W-DIV_LO_W){1'b0}}, prod[DIV_RECIP_SH +: DIV_LO_W]};

endmodule

>>> rtl/izhikevich_neuron_step_core.sv
// Izhikevich neuron step core: current accumulation and one Euler step per step-end word.
// Depends on izn_pkg, izn_mult and izn_div25.
//
// Usage:
//   req_ channel: tdata = input_current (Q16.16), tlast = step_end. A word with tlast low
//   adds its current to a saturating accumulator and gives no result.
//   A word with tlast high adds its current, then runs one Euler step of v and u.
//   rsp_ channel: tdata = {recovery_value, membrane_potential}, tuser = spiked.
//   csr_ channel: index/wdata writes of a, b, c, d, spike_peak, dt; always ready. The user must
//   write these only while the core is idle; the core does not enforce this. Indexes past dt are dropped.
// Sequence:
//   A step-end word holds req_tready low until the core returns to idle, so a new word is taken
//   only after the step is done. The step issues seven products in turn on one shared
//   32x32 multiplier (v*v, b*v, two for the divide by 25 of the 0.04*v*v term, a*(b*v-u),
//   du*dt, dv*dt), then a fire state updates v and u once the output register is free.
//   Accumulate-only words are taken every cycle while the core is idle.
// Reset: configuration returns to a=0.02, b=0.2, c=-65, d=8, peak=30, dt=1; v=0, u=-13,
//   accumulator cleared, no result pending.
// Stall: a pending result holds on rsp_ until taken; new words are still accepted, and a
//   following step end waits in its last stage until the output register is free.
module izhikevich_neuron_step_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // [31:0] input_current
   input  logic                           req_tlast,   // step_end
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,   // [31:0] membrane_potential, [63:32] recovery_value
   output logic                           rsp_tuser,   // [0] spiked
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [izn_pkg::IDX_W-1:0]      csr_index,
   input  logic [31:0]                    csr_wdata
);
   import izn_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_BV   = 4'd1;
   localparam logic [3:0] ST_DIFF = 4'd2;
   localparam logic [3:0] ST_AD   = 4'd3;
   localparam logic [3:0] ST_DU   = 4'd4;
   localparam logic [3:0] ST_DUT  = 4'd5;
   localparam logic [3:0] ST_NU   = 4'd6;
   localparam logic [3:0] ST_NV   = 4'd7;
   localparam logic [3:0] ST_FIRE = 4'd8;

   logic [3:0] st_ff, st_in;

   logic signed [DATA_W-1:0] a_ff, b_ff, c_ff, d_ff, peak_ff;
   logic [DT_W-1:0]          dt_ff;

   logic signed [DATA_W-1:0] v_ff, u_ff, sum_ff, tot_ff;
   logic signed [DATA_W-1:0] diff_ff, du_ff, dv_ff, nu_ff, nv_ff, nud_ff;
   logic signed [PART_W-1:0] part_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_spk_ff;
   logic signed [DATA_W-1:0] rsp_v_ff, rsp_u_ff;

   logic signed [DATA_W-1:0] op_a, op_b;
   logic signed [63:0]       prod;
   logic signed [63:0]       prod_sh;
   logic signed [DATA_W-1:0] hi_factor, lo_factor;
   logic [QUOT_W-1:0]        sq_quot;

   logic                     req_acc, out_free, fire;
   logic signed [63:0]       v64, u64, sum64, cur64, part64, nu64, d64, sq64;
   logic signed [DATA_W-1:0] tot_val, diff_val, du_val, nu_val, dv_val, nv_val, nud_val;
   logic signed [PART_W-1:0] v36, tot36, u36, part1, part2;
   logic signed [DATA_W-1:0] dt32;

   izn_mult u_mult (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   izn_div25 u_div (
      .clock     (clock),
      .split     (st_ff == ST_BV),
      .hold_hi   (st_ff == ST_AD),
      .prod      (prod),
      .hi_factor (hi_factor),
      .lo_factor (lo_factor),
      .quot      (sq_quot)
   );

   assign req_tready = (st_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign dt32    = {{(DATA_W-DT_W){1'b0}}, dt_ff};
   assign prod_sh = prod >>> 16;
   assign v64     = {{32{v_ff[31]}}, v_ff};
   assign u64     = {{32{u_ff[31]}}, u_ff};
   assign sum64   = {{32{sum_ff[31]}}, sum_ff};
   assign cur64   = {{32{req_tdata[31]}}, req_tdata};
   assign nu64    = {{32{nu_ff[31]}}, nu_ff};
   assign d64     = {{32{d_ff[31]}}, d_ff};
   assign part64  = {{(64-PART_W){part_ff[PART_W-1]}}, part_ff};
   assign sq64    = {{(64-QUOT_W){1'b0}}, sq_quot};
   assign v36     = {{(PART_W-DATA_W){v_ff[31]}}, v_ff};
   assign tot36   = {{(PART_W-DATA_W){tot_ff[31]}}, tot_ff};
   assign u36     = {{(PART_W-DATA_W){u_ff[31]}}, u_ff};

   assign tot_val  = sat32(sum64 + cur64);
   assign part1    = (v36 <<< 2) + v36 + tot36;
   assign part2    = part_ff + K140 - u36;
   assign diff_val = sat32(prod_sh - u64);
   assign du_val   = sat32(prod_sh);
   assign nu_val   = sat32(u64 + prod_sh);
   assign dv_val   = sat32(sq64 + part64);
   assign nv_val   = sat32(v64 + prod_sh);
   assign nud_val  = sat32(nu64 + d64);
   assign fire     = (nv_ff >= peak_ff);

   always_comb begin
      case (st_ff)
         ST_BV: begin
            op_a = b_ff;
            op_b = v_ff;
         end
         ST_DIFF: begin
            op_a = hi_factor;
            op_b = DIV_SPLIT_K;
         end
         ST_AD: begin
            op_a = a_ff;
            op_b = diff_ff;
         end
         ST_DU: begin
            op_a = lo_factor;
            op_b = DIV_RECIP;
         end
         ST_DUT: begin
            op_a = du_ff;
            op_b = dt32;
         end
         ST_NU: begin
            op_a = dv_ff;
            op_b = dt32;
         end
         default: begin
            op_a = v_ff;
            op_b = v_ff;
         end
      endcase
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (req_acc && req_tlast) st_in = ST_BV;
         ST_BV:   st_in = ST_DIFF;
         ST_DIFF: st_in = ST_AD;
         ST_AD:   st_in = ST_DU;
         ST_DU:   st_in = ST_DUT;
         ST_DUT:  st_in = ST_NU;
         ST_NU:   st_in = ST_NV;
         ST_NV:   st_in = ST_FIRE;
         ST_FIRE: if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (st_ff == ST_FIRE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         a_ff         <= RST_A;
         b_ff         <= RST_B;
         c_ff         <= RST_C;
         d_ff         <= RST_D;
         peak_ff      <= RST_PEAK;
         dt_ff        <= RST_DT;
         v_ff         <= '0;
         u_ff         <= RST_U;
         sum_ff       <= '0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_A:    a_ff    <= csr_wdata;
               REG_B:    b_ff    <= csr_wdata;
               REG_C:    c_ff    <= csr_wdata;
               REG_D:    d_ff    <= csr_wdata;
               REG_PEAK: peak_ff <= csr_wdata;
               REG_DT:   dt_ff   <= csr_wdata[DT_W-1:0];
               default: ;
            endcase
         end
         if (req_acc) begin
            sum_ff <= req_tlast ? '0 : tot_val;
         end
         if (st_ff == ST_FIRE && out_free) begin
            v_ff <= fire ? c_ff : nv_ff;
            u_ff <= fire ? nud_ff : nu_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) tot_ff <= tot_val;
      case (st_ff)
         ST_BV:   part_ff <= part1;
         ST_DIFF: begin
            part_ff <= part2;
            diff_ff <= diff_val;
         end
         ST_DU:   du_ff <= du_val;
         ST_DUT:  dv_ff <= dv_val;
         ST_NU:   nu_ff <= nu_val;
         ST_NV: begin
            nv_ff  <= nv_val;
            nud_ff <= nud_val;
         end
         ST_FIRE: begin
            if (out_free) begin
               rsp_spk_ff <= fire;
               rsp_v_ff   <= fire ? c_ff : nv_ff;
               rsp_u_ff   <= fire ? nud_ff : nu_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_u_ff, rsp_v_ff};
   assign rsp_tuser  = rsp_spk_ff;

endmodule

>>> rtl/izn_checker.sv
// Port-level checker for the Izhikevich neuron step core, bound to the top level.
// Depends on izn_pkg and izhikevich_neuron_step_core_macros.svh.
`include "izhikevich_neuron_step_core_macros.svh"

module izn_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [31:0]               req_tdata,
   input logic                      req_tlast,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [63:0]               rsp_tdata,
   input logic                      rsp_tuser,
   input logic                      csr_valid,
   input logic                      csr_ready,
   input logic [izn_pkg::IDX_W-1:0] csr_index,
   input logic [31:0]               csr_wdata
);
   import izn_pkg::*;

   logic req_word, csr_word, step_word, add_word;

   assign req_word  = req_tvalid && req_tready;
   assign csr_word  = csr_valid && csr_ready && (csr_index <= REG_DT) && (|csr_wdata || 1'b1);
   assign step_word = req_word && req_tlast;
   assign add_word  = req_word && !req_tlast && (|req_tdata || 1'b1);

   `IZN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result word changed")
   `IZN_ASSERT_NEXT(a_step_busy, clock, reset, step_word, !req_tready, "ready after a step-end word")
   `IZN_ASSERT_NEXT(a_add_quiet, clock, reset, add_word && !rsp_tvalid, !rsp_tvalid, "result without a step-end word")
   `IZN_ASSERT_NOW(a_rise_busy, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result rose while core was idle")
   `IZN_ASSERT_NOW(a_csr_open, clock, reset, csr_word || !csr_word, csr_ready, "configuration port not ready")

endmodule

bind izhikevich_neuron_step_core izn_checker u_izn_checker (.*);
